// ===== rtl/core/ssd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared widths, codes, reset values and types of the sweep/sync pulse
// decoder.
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned CoordW   = 16;
  localparam int unsigned ThrW     = 8;
  localparam int unsigned SpurW    = 6;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [ThrW-1:0]  SweepThresholdRst = 8'd50;
  localparam logic [ThrW-1:0]  SyncMaxWidthRst   = 8'd140;
  localparam logic [SpurW-1:0] SpuriousLimitRst  = 6'd60;
  localparam logic [SpurW-1:0] SpurMax           = 6'd63;

  localparam logic [TimeW-1:0] XBandMin  = 32'd75;
  localparam logic [TimeW-1:0] GapALow   = 32'd85;
  localparam logic [TimeW-1:0] GapAHigh  = 32'd95;
  localparam logic [TimeW-1:0] GapBLow   = 32'd106;
  localparam logic [TimeW-1:0] GapBHigh  = 32'd117;
  localparam logic [TimeW-1:0] GapCLow   = 32'd127;
  localparam logic [TimeW-1:0] GapCHigh  = 32'd137;

  typedef enum logic [1:0] {
    AXIS_NONE = 2'd0,
    AXIS_X    = 2'd1,
    AXIS_Y    = 2'd2
  } axis_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SWEEP_THRESHOLD = 2'd0,
    CFG_SYNC_MAX_WIDTH  = 2'd1,
    CFG_SPURIOUS_LIMIT  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [ThrW-1:0]  sweep_threshold;
    logic [ThrW-1:0]  sync_max_width;
    logic [SpurW-1:0] spurious_limit;
  } cfg_t;

  typedef struct packed {
    logic  is_sweep;
    logic  is_spurious;
    axis_e axis;
  } pulse_class_t;

  typedef struct packed {
    logic [CoordW-1:0] x_coord;
    logic [CoordW-1:0] y_coord;
    logic              lost;
    logic              updated;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/ssd_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_if
// Valid/ready channels of the decoder: edge input, result output and
// configuration write.
// ----------------------------------------------------------------------------
interface ssd_edge_if;
  logic        valid;
  logic        ready;
  logic        level;
  logic [31:0] time_us;

  modport source (output valid, output level, output time_us, input ready);
  modport sink   (input valid, input level, input time_us, output ready);
endinterface

interface ssd_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] x_coord;
  logic [15:0] y_coord;
  logic        lost;
  logic        updated;

  modport source (output valid, output x_coord, output y_coord, output lost,
                  output updated, input ready);
  modport sink   (input valid, input x_coord, input y_coord, input lost,
                  input updated, output ready);
endinterface

interface ssd_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ssd_classify.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_classify
// Classifies a pulse width as sweep, spurious sync or X/Y sync pulse.
// ----------------------------------------------------------------------------
module ssd_classify
  import ssd_pkg::*;
(
  input  logic [TimeW-1:0] width_i,
  input  cfg_t             cfg_i,
  output pulse_class_t     class_o
);

  logic in_x_band;

  always_comb begin
    in_x_band = (width_i >= XBandMin)
              && !((width_i > GapALow) && (width_i < GapAHigh))
              && !((width_i > GapBLow) && (width_i < GapBHigh))
              && !((width_i > GapCLow) && (width_i < GapCHigh));
    class_o.is_sweep    = (width_i <= TimeW'(cfg_i.sweep_threshold));
    class_o.is_spurious = (width_i > TimeW'(cfg_i.sync_max_width));
    class_o.axis        = in_x_band ? AXIS_X : AXIS_Y;
  end

endmodule
`default_nettype wire

// ===== rtl/core/ssd_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_core
// Edge time state, pulse analysis, axis selection, coordinate holds and
// loss tracking, updated once per advancing edge.
// ----------------------------------------------------------------------------
module ssd_core
  import ssd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  logic             level_i,
  input  logic [TimeW-1:0] time_us_i,
  input  cfg_t             cfg_i,
  output result_t          result_o
);

  logic [TimeW-1:0]  rise_q, rise_d;
  logic [TimeW-1:0]  fall_q, fall_d;
  logic [TimeW-1:0]  prev_fall_q, prev_fall_d;
  axis_e             axis_q, axis_d;
  logic [CoordW-1:0] x_q, x_d;
  logic [CoordW-1:0] y_q, y_d;
  logic [SpurW-1:0]  spur_q, spur_d;
  logic              lost_q, lost_d;

  logic              analyze;
  logic              updated;
  logic [TimeW-1:0]  width;
  logic [TimeW-1:0]  delay_full;
  pulse_class_t      pclass;

  assign rise_d     = level_i ? time_us_i : rise_q;
  assign fall_d     = level_i ? fall_q : time_us_i;
  assign analyze    = !lost_q && (fall_d != prev_fall_q);
  assign width      = fall_d - rise_d;
  assign delay_full = rise_d - prev_fall_q;

  ssd_classify u_classify (
    .width_i (width),
    .cfg_i   (cfg_i),
    .class_o (pclass)
  );

  always_comb begin
    prev_fall_d = prev_fall_q;
    axis_d      = axis_q;
    x_d         = x_q;
    y_d         = y_q;
    spur_d      = spur_q;
    updated     = 1'b0;
    if (analyze) begin
      prev_fall_d = fall_d;
      if (!pclass.is_sweep) begin
        if (pclass.is_spurious) begin
          axis_d = AXIS_NONE;
          if (spur_q < SpurMax) begin
            spur_d = spur_q + SpurW'(1);
          end
        end else begin
          axis_d = pclass.axis;
        end
      end else begin
        case (axis_q)
          AXIS_X: begin
            x_d     = delay_full[CoordW-1:0];
            updated = 1'b1;
          end
          AXIS_Y: begin
            y_d     = delay_full[CoordW-1:0];
            updated = 1'b1;
          end
          default: begin
            updated = 1'b0;
          end
        endcase
        spur_d = '0;
      end
    end
    lost_d = lost_q | (analyze && (spur_d > cfg_i.spurious_limit));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_q      <= '0;
      fall_q      <= '0;
      prev_fall_q <= '0;
      axis_q      <= AXIS_NONE;
      x_q         <= '0;
      y_q         <= '0;
      spur_q      <= '0;
      lost_q      <= 1'b0;
    end else if (advance_i) begin
      rise_q      <= rise_d;
      fall_q      <= fall_d;
      prev_fall_q <= prev_fall_d;
      axis_q      <= axis_d;
      x_q         <= x_d;
      y_q         <= y_d;
      spur_q      <= spur_d;
      lost_q      <= lost_d;
    end
  end

  assign result_o.x_coord = x_d;
  assign result_o.y_coord = y_d;
  assign result_o.lost    = lost_d;
  assign result_o.updated = updated;

endmodule
`default_nettype wire

// ===== rtl/core/sweep_sync_pulse_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sweep_sync_pulse_decoder
// An accepted edge passes the input register, then the result register
// written as the decoder state updates. Throughput: one edge per cycle
// unless the result stalls, limited by the single state update path.
// Reset: asynchronous, active low; clears control and decoder state, not data
// registers; restores register defaults; decoding runs right after reset.
// ----------------------------------------------------------------------------
module sweep_sync_pulse_decoder
  import ssd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  ssd_edge_if.sink     edge_i,
  ssd_cfg_if.sink      cfg_i,
  ssd_result_if.source result_o
);

  cfg_t             cfg_q;
  logic             in_vld_q;
  logic             in_level_q;
  logic [TimeW-1:0] in_time_q;
  logic             out_vld_q;
  result_t          out_q;
  result_t          core_res;
  logic             advance;
  logic             edge_acc;

  assign advance      = in_vld_q && (!out_vld_q || result_o.ready);
  assign edge_i.ready = !in_vld_q || advance;
  assign edge_acc     = edge_i.valid && edge_i.ready;
  assign cfg_i.ready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sweep_threshold <= SweepThresholdRst;
      cfg_q.sync_max_width  <= SyncMaxWidthRst;
      cfg_q.spurious_limit  <= SpuriousLimitRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_SWEEP_THRESHOLD: cfg_q.sweep_threshold <= cfg_i.data;
        CFG_SYNC_MAX_WIDTH:  cfg_q.sync_max_width  <= cfg_i.data;
        CFG_SPURIOUS_LIMIT:  cfg_q.spurious_limit  <= cfg_i.data[SpurW-1:0];
        default:             cfg_q                 <= cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (edge_acc) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (edge_acc) begin
      in_level_q <= edge_i.level;
      in_time_q  <= edge_i.time_us;
    end
    if (advance) begin
      out_q <= core_res;
    end
  end

  ssd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .level_i   (in_level_q),
    .time_us_i (in_time_q),
    .cfg_i     (cfg_q),
    .result_o  (core_res)
  );

  assign result_o.valid   = out_vld_q;
  assign result_o.x_coord = out_q.x_coord;
  assign result_o.y_coord = out_q.y_coord;
  assign result_o.lost    = out_q.lost;
  assign result_o.updated = out_q.updated;

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// Sweep/sync pulse decoder testbench
// Drives signal edges into the decoder over its valid/ready channels and
// checks every result against a cycle-free predictor of the decoding: width
// classification, axis selection, 16-bit sweep timing, the spurious count
// and the latched lost status. Register settings change between phases,
// both channels idle at random, and the run ends by driving the decoder
// into the lost state.
// ----------------------------------------------------------------------------
module testbench
  import ssd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit      = 400000;
  localparam int unsigned LongStallCycles = 300;
  localparam int unsigned DrainCycles     = 6;
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 2'd3;

  class sweep_scoreboard;
    logic [ThrW-1:0]   thr_cfg;
    logic [ThrW-1:0]   maxw_cfg;
    logic [SpurW-1:0]  limit_cfg;
    logic [TimeW-1:0]  rise_t;
    logic [TimeW-1:0]  fall_t;
    logic [TimeW-1:0]  prev_fall_t;
    axis_e             axis;
    logic [CoordW-1:0] x_hold;
    logic [CoordW-1:0] y_hold;
    logic [SpurW-1:0]  spur_cnt;
    bit                lost_q;
    result_t           expected_coords[$];
    int unsigned       mismatches;
    int unsigned       results_seen;
    int unsigned       n_sync_x;
    int unsigned       n_sync_y;
    int unsigned       n_spurious;
    int unsigned       n_upd_x;
    int unsigned       n_upd_y;
    int unsigned       n_no_axis;

    function new();
      thr_cfg     = SweepThresholdRst;
      maxw_cfg    = SyncMaxWidthRst;
      limit_cfg   = SpuriousLimitRst;
      rise_t      = '0;
      fall_t      = '0;
      prev_fall_t = '0;
      axis        = AXIS_NONE;
      x_hold      = '0;
      y_hold      = '0;
      spur_cnt    = '0;
      lost_q      = 1'b0;
    endfunction

    function void configure(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        CFG_SWEEP_THRESHOLD: thr_cfg = val;
        CFG_SYNC_MAX_WIDTH:  maxw_cfg = val;
        CFG_SPURIOUS_LIMIT:  limit_cfg = val[SpurW-1:0];
        default: ;
      endcase
    endfunction

    function bit x_band(logic [TimeW-1:0] w);
      return (w >= XBandMin) && !(w > GapALow && w < GapAHigh) &&
             !(w > GapBLow && w < GapBHigh) && !(w > GapCLow && w < GapCHigh);
    endfunction

    function result_t decode_edge(logic lvl, logic [TimeW-1:0] t);
      result_t r;
      logic [TimeW-1:0] width;
      logic [TimeW-1:0] delay;
      r.updated = 1'b0;
      if (lvl) rise_t = t;
      else fall_t = t;
      if (!lost_q && fall_t != prev_fall_t) begin
        width = fall_t - rise_t;
        if (width > thr_cfg) begin
          if (width > maxw_cfg) begin
            axis = AXIS_NONE;
            n_spurious++;
            if (spur_cnt != SpurMax) spur_cnt++;
          end else if (x_band(width)) begin
            axis = AXIS_X;
            n_sync_x++;
          end else begin
            axis = AXIS_Y;
            n_sync_y++;
          end
        end else begin
          delay = rise_t - prev_fall_t;
          case (axis)
            AXIS_X: begin
              x_hold = delay[CoordW-1:0];
              r.updated = 1'b1;
              n_upd_x++;
            end
            AXIS_Y: begin
              y_hold = delay[CoordW-1:0];
              r.updated = 1'b1;
              n_upd_y++;
            end
            default: n_no_axis++;
          endcase
          spur_cnt = '0;
        end
        if (spur_cnt > limit_cfg) lost_q = 1'b1;
        prev_fall_t = fall_t;
      end
      r.x_coord = x_hold;
      r.y_coord = y_hold;
      r.lost    = lost_q;
      return r;
    endfunction

    function void note_edge(logic lvl, logic [TimeW-1:0] t);
      expected_coords.push_back(decode_edge(lvl, t));
    endfunction

    function void compare_field(string name, int unsigned exp, int unsigned got);
      if (exp != got) begin
        $error("%s: expected %0d, got %0d", name, exp, got);
        mismatches++;
      end
    endfunction

    function void check_result(result_t got);
      result_t exp;
      results_seen++;
      if (expected_coords.size() == 0) begin
        $error("result transaction with no edge outstanding");
        mismatches++;
        return;
      end
      exp = expected_coords.pop_front();
      compare_field("x_coord", exp.x_coord, got.x_coord);
      compare_field("y_coord", exp.y_coord, got.y_coord);
      compare_field("lost", exp.lost, got.lost);
      compare_field("updated", exp.updated, got.updated);
    endfunction

    function int unsigned pending();
      return expected_coords.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  ssd_edge_if   edge_if ();
  ssd_cfg_if    cfg_if ();
  ssd_result_if res_if ();

  sweep_sync_pulse_decoder uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .edge_i   (edge_if),
    .cfg_i    (cfg_if),
    .result_o (res_if)
  );

  sweep_scoreboard sb;
  result_t         seen;
  logic [TimeW-1:0] now_us;
  int unsigned     edges_sent;
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;
  bit              long_stall_req;
  int unsigned     cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("** sweep_sync_pulse_decoder: FAILED **");
      $finish;
    end
  end

  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_stall_req) begin
        res_if.ready <= 1'b0;
        repeat (LongStallCycles) @(negedge clk_i);
        long_stall_req = 1'b0;
      end
      res_if.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      seen.x_coord = res_if.x_coord;
      seen.y_coord = res_if.y_coord;
      seen.lost    = res_if.lost;
      seen.updated = res_if.updated;
      sb.check_result(seen);
    end
  end

  task automatic send_edge(input logic lvl, input logic [TimeW-1:0] t);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      edge_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    edge_if.valid   <= 1'b1;
    edge_if.level   <= lvl;
    edge_if.time_us <= t;
    do @(posedge clk_i); while (!edge_if.ready);
    sb.note_edge(lvl, t);
    edges_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_pulse(input int unsigned gap, input int unsigned width);
    logic [TimeW-1:0] rise_at;
    rise_at = now_us + gap;
    send_edge(1'b1, rise_at);
    send_edge(1'b0, rise_at + width);
    now_us = rise_at + width;
  endtask

  task automatic wait_drained();
    edge_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.configure(idx, val);
    @(negedge clk_i);
  endtask

  task automatic configure_decoder(input int unsigned thr, input int unsigned maxw,
                                   input int unsigned limit);
    wait_drained();
    write_reg(CFG_SWEEP_THRESHOLD, CfgDataW'(thr));
    write_reg(CFG_SYNC_MAX_WIDTH, CfgDataW'(maxw));
    write_reg(CFG_SPURIOUS_LIMIT, CfgDataW'(limit));
    cfg_if.valid <= 1'b0;
  endtask

  function automatic int unsigned sweep_width();
    return $urandom_range(int'(sb.thr_cfg), 0);
  endfunction

  function automatic int unsigned spur_width();
    int unsigned lo;
    lo = ((sb.thr_cfg > sb.maxw_cfg) ? int'(sb.thr_cfg) : int'(sb.maxw_cfg)) + 1;
    return $urandom_range(lo + 400, lo);
  endfunction

  function automatic int unsigned sync_width();
    if (sb.maxw_cfg > sb.thr_cfg) return $urandom_range(int'(sb.maxw_cfg), int'(sb.thr_cfg) + 1);
    return spur_width();
  endfunction

  function automatic int unsigned sweep_delay();
    if ($urandom_range(9, 0) == 0) return $urandom_range(32'h0003_FFFF, 32'h0001_0000);
    return $urandom_range(60000, 0);
  endfunction

  task automatic send_frame(input bit keep_alive);
    int unsigned pick;
    pick = $urandom_range(99, 0);
    if (keep_alive) begin
      while (!sb.lost_q && sb.spur_cnt + 3 > sb.limit_cfg) begin
        send_pulse($urandom_range(5000, 10), sweep_width());
      end
    end
    if ($urandom_range(19, 0) == 0) now_us = $urandom();
    if (pick < 65) begin
      send_pulse($urandom_range(20000, 0), sync_width());
      repeat ($urandom_range(3, 1)) send_pulse(sweep_delay(), sweep_width());
    end else if (pick < 77) begin
      send_pulse($urandom_range(5000, 0), spur_width());
    end else if (pick < 89) begin
      send_edge($urandom_range(1, 0) == 1, $urandom());
    end else if (pick < 93) begin
      send_edge(1'b1, now_us + $urandom_range(3000, 0));
    end else if (pick < 97) begin
      send_edge(1'b0, sb.prev_fall_t);
    end else begin
      send_pulse(sweep_delay(), sweep_width());
    end
  endtask

  task automatic run_random(input int unsigned n, input bit keep_alive);
    int unsigned target;
    target = edges_sent + n;
    while (edges_sent < target) send_frame(keep_alive);
  endtask

  initial begin
    sb              = new();
    rst_ni          = 1'b0;
    edges_sent      = 0;
    now_us          = '0;
    long_stall_req  = 1'b0;
    edge_if.valid   = 1'b0;
    edge_if.level   = 1'b0;
    edge_if.time_us = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = CFG_SWEEP_THRESHOLD;
    cfg_if.data     = '0;
    send_idle_pct   = 37;
    recv_idle_pct   = 47;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_edge(1'b0, 32'd0);
    send_edge(1'b1, 32'd1000);
    send_edge(1'b0, 32'd1010);
    send_edge(1'b1, 32'd2000);
    send_edge(1'b0, 32'd2075);
    send_edge(1'b1, 32'h0001_2000);
    send_edge(1'b0, 32'h0001_2005);
    send_edge(1'b1, 32'h0001_3000);
    send_edge(1'b0, 32'h0001_3056);
    send_edge(1'b1, 32'h0001_3100);
    send_edge(1'b0, 32'h0001_3132);
    send_edge(1'b0, 32'h0001_3132);
    send_edge(1'b1, 32'h0001_4000);
    send_edge(1'b0, 32'h0001_408D);
    send_edge(1'b1, 32'h0001_4200);
    send_edge(1'b0, 32'h0001_4233);
    send_edge(1'b1, 32'hFFFF_FFF0);
    send_edge(1'b0, 32'h0000_0070);
    send_edge(1'b1, 32'hFFFF_FFFF);
    send_edge(1'b0, 32'h0000_0003);
    send_edge(1'b1, 32'h0000_1000);
    send_edge(1'b0, 32'h0000_108C);
    send_edge(1'b1, 32'h0000_2000);
    send_edge(1'b0, 32'h0000_2001);
    now_us = 32'h0000_2001;
    run_random(210, 1'b1);

    configure_decoder(0, 255, 63);
    send_pulse(1000, 200);
    send_pulse(500, 0);
    repeat (70) send_pulse(100, 300);
    send_pulse(800, 0);
    run_random(210, 1'b1);

    send_idle_pct = 47;
    recv_idle_pct = 37;
    configure_decoder(255, 0, 62);
    @(negedge clk_i);
    write_reg(CfgIdxUnused, 8'hA5);
    cfg_if.valid <= 1'b0;
    run_random(210, 1'b1);

    configure_decoder(60, 180, 10);
    run_random(210, 1'b1);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure_decoder($urandom_range(255, 0), $urandom_range(255, 0), $urandom_range(63, 3));
    long_stall_req = 1'b1;
    run_random(210, 1'b1);

    configure_decoder(50, 140, 0);
    run_random(150, 1'b0);

    wait_drained();
    $display("Sent %0d edges, checked %0d results; syncs X %0d, Y %0d, spurious %0d.",
             edges_sent, sb.results_seen, sb.n_sync_x, sb.n_sync_y, sb.n_spurious);
    $display("Coordinate updates X %0d, Y %0d; sweeps with no axis %0d; lost reached: %0d.",
             sb.n_upd_x, sb.n_upd_y, sb.n_no_axis, sb.lost_q);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** sweep_sync_pulse_decoder: PASSED **");
    end else begin
      $display("** sweep_sync_pulse_decoder: FAILED **");
    end
    $finish;
  end

endmodule
